[design/lcwv_pkg.sv]
// ----------------------------------------------------------------------------
// lcwv_pkg
// Shared types, codes and helpers of the line clip and viewport map block.
// ----------------------------------------------------------------------------
package lcwv_pkg;

  localparam int COORD_BITS   = 12;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int ROUND_LIMIT  = 8;
  localparam int ROUND_BITS   = $clog2(ROUND_LIMIT + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int REG_COUNT    = 8;
  localparam int ADDR_BITS    = $clog2(REG_COUNT) + 2;

  // region code bits
  localparam logic [3:0] CODE_L = 4'b1000;
  localparam logic [3:0] CODE_R = 4'b0100;
  localparam logic [3:0] CODE_B = 4'b0010;
  localparam logic [3:0] CODE_T = 4'b0001;

  // register reset values
  localparam logic [COORD_BITS-1:0] WIN_MIN_RST  = COORD_BITS'(50);
  localparam logic [COORD_BITS-1:0] WIN_MAX_RST  = COORD_BITS'(300);
  localparam logic [COORD_BITS-1:0] VIEW_MIN_RST = COORD_BITS'(250);
  localparam logic [COORD_BITS-1:0] VIEW_MAX_RST = COORD_BITS'(500);

  typedef enum logic [2:0] {
    REG_WIN_X_MIN  = 3'd0,
    REG_WIN_Y_MIN  = 3'd1,
    REG_WIN_X_MAX  = 3'd2,
    REG_WIN_Y_MAX  = 3'd3,
    REG_VIEW_X_MIN = 3'd4,
    REG_VIEW_Y_MIN = 3'd5,
    REG_VIEW_X_MAX = 3'd6,
    REG_VIEW_Y_MAX = 3'd7
  } reg_idx_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] ucoord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    logic    visible;
    ucoord_t out_start_x;
    ucoord_t out_start_y;
    ucoord_t out_end_x;
    ucoord_t out_end_y;
  } out_item_t;

  // classified segment handed from front to back
  typedef struct packed {
    in_item_t   seg;
    logic [3:0] code_a;
    logic [3:0] code_b;
  } seg_t;

  typedef struct packed {
    coord_t  win_x_min;
    coord_t  win_y_min;
    coord_t  win_x_max;
    coord_t  win_y_max;
    ucoord_t view_x_min;
    ucoord_t view_y_min;
    ucoord_t view_x_max;
    ucoord_t view_y_max;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_SETM,
    ST_MUL,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } back_state_t;

  // region code of one point against the window
  function automatic logic [3:0] region_code(coord_t x, coord_t y, cfg_t c);
    logic [3:0] r;
    r = '0;
    if (x < c.win_x_min) r = r | CODE_L;
    if (x > c.win_x_max) r = r | CODE_R;
    if (y < c.win_y_min) r = r | CODE_B;
    if (y > c.win_y_max) r = r | CODE_T;
    return r;
  endfunction

endpackage

[design/line_clip_window_viewport_top.sv]
// ----------------------------------------------------------------------------
// line_clip_window_viewport_top
// Cohen-Sutherland line clipper with window to viewport mapping.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_item carry one segment (signed endpoints) per item.
//   out_valid/out_ready/out_item return one result per item: visible flag and
//   the clipped endpoints mapped into the viewport (zero when hidden).
//   Window and viewport edges are written through the APB port; users must
//   write them only while no item is in flight. The block does not check it.
// Sequencing:
//   each clip round and each of the four mapped coordinates run on the
//   26-step serial divider shared by both, which is skipped when the
//   divisor is zero. A trivially rejected segment goes straight to
//   out_valid; an accepted one first has its four coordinates mapped.
//   The front register and a two-item queue let up to three segments be
//   taken while the back end works.
// Reset: rst clears all control state and loads the default window
//   (50..300) and viewport (250..500).
// Stall: a held result stays on out_item; the back end waits, the queue
//   fills and in_ready then drops.
// ----------------------------------------------------------------------------
module line_clip_window_viewport_top import lcwv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     f_valid, f_ready, q_valid, q_ready;
  seg_t     f_seg, q_seg;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_x_min  <= WIN_MIN_RST;
      cfg.win_y_min  <= WIN_MIN_RST;
      cfg.win_x_max  <= WIN_MAX_RST;
      cfg.win_y_max  <= WIN_MAX_RST;
      cfg.view_x_min <= VIEW_MIN_RST;
      cfg.view_y_min <= VIEW_MIN_RST;
      cfg.view_x_max <= VIEW_MAX_RST;
      cfg.view_y_max <= VIEW_MAX_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_WIN_X_MIN:  cfg.win_x_min  <= pwdata[COORD_BITS-1:0];
        REG_WIN_Y_MIN:  cfg.win_y_min  <= pwdata[COORD_BITS-1:0];
        REG_WIN_X_MAX:  cfg.win_x_max  <= pwdata[COORD_BITS-1:0];
        REG_WIN_Y_MAX:  cfg.win_y_max  <= pwdata[COORD_BITS-1:0];
        REG_VIEW_X_MIN: cfg.view_x_min <= pwdata[COORD_BITS-1:0];
        REG_VIEW_Y_MIN: cfg.view_y_min <= pwdata[COORD_BITS-1:0];
        REG_VIEW_X_MAX: cfg.view_x_max <= pwdata[COORD_BITS-1:0];
        default:        cfg.view_y_max <= pwdata[COORD_BITS-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      REG_WIN_X_MIN:  prdata = 32'(cfg.win_x_min);
      REG_WIN_Y_MIN:  prdata = 32'(cfg.win_y_min);
      REG_WIN_X_MAX:  prdata = 32'(cfg.win_x_max);
      REG_WIN_Y_MAX:  prdata = 32'(cfg.win_y_max);
      REG_VIEW_X_MIN: prdata = 32'(cfg.view_x_min);
      REG_VIEW_Y_MIN: prdata = 32'(cfg.view_y_min);
      REG_VIEW_X_MAX: prdata = 32'(cfg.view_x_max);
      default:        prdata = 32'(cfg.view_y_max);
    endcase
  end

  lcwv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .seg_valid (f_valid),
    .seg_ready (f_ready),
    .seg       (f_seg)
  );

  lcwv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_seg),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_seg)
  );

  lcwv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .seg_valid (q_valid),
    .seg_ready (q_ready),
    .seg       (q_seg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[design/lcwv_front.sv]
// ----------------------------------------------------------------------------
// lcwv_front
// Accepts segments and registers them with the region codes of both ends.
// ----------------------------------------------------------------------------
module lcwv_front import lcwv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     seg_valid,
  input  logic     seg_ready,
  output seg_t     seg
);

  logic held;

  assign in_ready  = !held || seg_ready;
  assign seg_valid = held;

  // holding register with codes
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_valid && in_ready) begin
      seg.seg    <= in_item;
      seg.code_a <= region_code(in_item.start_x, in_item.start_y, cfg);
      seg.code_b <= region_code(in_item.end_x, in_item.end_y, cfg);
    end
  end

endmodule

[design/lcwv_queue.sv]
// ----------------------------------------------------------------------------
// lcwv_queue
// Short queue of classified segments between front and back.
// ----------------------------------------------------------------------------
module lcwv_queue import lcwv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  seg_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output seg_t pop_data
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  seg_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != CNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

[design/lcwv_div.sv]
// ----------------------------------------------------------------------------
// lcwv_div
// Signed restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module lcwv_div import lcwv_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [PROD_BITS-1:0] num,
  input  logic signed [DIFF_BITS-1:0] den,
  output logic                        busy,
  output logic                        done,
  output logic signed [PROD_BITS-1:0] quot
);

  localparam int CNT_BITS = $clog2(PROD_BITS + 1);

  logic [CNT_BITS-1:0]  cnt;
  logic [PROD_BITS-1:0] quo;
  logic [DIFF_BITS-1:0] rem;
  logic [DIFF_BITS-1:0] dmag;
  logic                 neg;
  logic [DIFF_BITS:0]   trial;

  assign busy  = cnt != '0;
  assign trial = {rem, quo[PROD_BITS-1]};
  assign quot  = neg ? -$signed(quo) : $signed(quo);

  // shift and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_BITS'(1));
      if (start) begin
        cnt <= CNT_BITS'(PROD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
      end
    end
    if (start) begin
      quo  <= num[PROD_BITS-1] ? PROD_BITS'(-num) : PROD_BITS'(num);
      dmag <= den[DIFF_BITS-1] ? DIFF_BITS'(-den) : DIFF_BITS'(den);
      neg  <= num[PROD_BITS-1] ^ den[DIFF_BITS-1];
      rem  <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, dmag}) begin
        rem <= DIFF_BITS'(trial - {1'b0, dmag});
        quo <= {quo[PROD_BITS-2:0], 1'b1};
      end else begin
        rem <= trial[DIFF_BITS-1:0];
        quo <= {quo[PROD_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

[design/lcwv_back.sv]
// ----------------------------------------------------------------------------
// lcwv_back
// Clip rounds and viewport mapping on one multiplier and a shared divider.
// ----------------------------------------------------------------------------
module lcwv_back import lcwv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      seg_valid,
  output logic      seg_ready,
  input  seg_t      seg,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  back_state_t state, state_next;

  coord_t                      ax, ay, bx, by;
  logic [3:0]                  ca, cb;
  logic [ROUND_BITS-1:0]       round;
  logic                        mapping;
  logic [1:0]                  map_idx;
  logic                        move_a;
  logic                        fix_y;
  coord_t                      fix_val;
  logic signed [DIFF_BITS-1:0] base, d1, d2, den;
  logic signed [PROD_BITS-1:0] prod;
  coord_t                      res;

  logic                        div_start;
  logic                        div_busy;
  logic                        div_done;
  logic signed [PROD_BITS-1:0] div_quot;
  logic signed [PROD_BITS-1:0] sum;

  logic                        trivial_acc;
  logic                        trivial_rej;
  logic [3:0]                  sel_code;
  coord_t                      px, py, qx, qy;
  coord_t                      mp, wmin, wmax;
  ucoord_t                     vmin, vmax;
  coord_t                      nx, ny;

  lcwv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // product of the registered operands, taken by the divider at start
  assign prod        = PROD_BITS'(d1) * PROD_BITS'(d2);

  assign trivial_acc = (ca == '0) && (cb == '0);
  assign trivial_rej = ((ca & cb) != '0) || (round == ROUND_BITS'(ROUND_LIMIT));
  assign sel_code    = (ca != '0) ? ca : cb;
  assign px          = (ca != '0) ? ax : bx;
  assign py          = (ca != '0) ? ay : by;
  assign qx          = (ca != '0) ? bx : ax;
  assign qy          = (ca != '0) ? by : ay;
  assign sum         = PROD_BITS'(base) + div_quot;
  assign nx          = fix_y ? res : fix_val;
  assign ny          = fix_y ? fix_val : res;

  // axis picked for mapping
  always_comb begin
    case (map_idx)
      2'd0: mp = ax;
      2'd1: mp = ay;
      2'd2: mp = bx;
      default: mp = by;
    endcase
    if (map_idx[0]) begin
      wmin = cfg.win_y_min;
      wmax = cfg.win_y_max;
      vmin = cfg.view_y_min;
      vmax = cfg.view_y_max;
    end else begin
      wmin = cfg.win_x_min;
      wmax = cfg.win_x_max;
      vmin = cfg.view_x_min;
      vmax = cfg.view_x_max;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (seg_valid) state_next = ST_TEST;
      ST_TEST: begin
        if (trivial_acc)      state_next = ST_SETM;
        else if (trivial_rej) state_next = ST_OUT;
        else                  state_next = ST_MUL;
      end
      ST_SETM: state_next = ST_MUL;
      ST_MUL:  state_next = (den == '0) ? ST_UPD : ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_UPD;
      ST_UPD: begin
        if (!mapping)                  state_next = ST_TEST;
        else if (map_idx == 2'd3)      state_next = ST_OUT;
        else                           state_next = ST_SETM;
      end
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    seg_ready = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_IDLE: seg_ready = 1'b1;
      ST_MUL:  div_start = (den != '0);
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ax       <= seg.seg.start_x;
        ay       <= seg.seg.start_y;
        bx       <= seg.seg.end_x;
        by       <= seg.seg.end_y;
        ca       <= seg.code_a;
        cb       <= seg.code_b;
        round    <= '0;
        mapping  <= 1'b0;
        map_idx  <= '0;
        out_item <= '0;
      end
      ST_TEST: begin
        move_a <= (ca != '0);
        if (trivial_acc) begin
          mapping          <= 1'b1;
          out_item.visible <= 1'b1;
        end else if ((sel_code & CODE_T) != '0 || (sel_code & CODE_B) != '0) begin
          // horizontal edge, solve for x
          fix_y   <= 1'b1;
          fix_val <= ((sel_code & CODE_T) != '0) ? cfg.win_y_max : cfg.win_y_min;
          base    <= DIFF_BITS'(px);
          d1      <= DIFF_BITS'(((sel_code & CODE_T) != '0) ? cfg.win_y_max
                                                             : cfg.win_y_min)
                     - DIFF_BITS'(py);
          d2      <= DIFF_BITS'(qx) - DIFF_BITS'(px);
          den     <= DIFF_BITS'(qy) - DIFF_BITS'(py);
        end else begin
          // vertical edge, solve for y
          fix_y   <= 1'b0;
          fix_val <= ((sel_code & CODE_R) != '0) ? cfg.win_x_max : cfg.win_x_min;
          base    <= DIFF_BITS'(py);
          d1      <= DIFF_BITS'(((sel_code & CODE_R) != '0) ? cfg.win_x_max
                                                             : cfg.win_x_min)
                     - DIFF_BITS'(px);
          d2      <= DIFF_BITS'(qy) - DIFF_BITS'(py);
          den     <= DIFF_BITS'(qx) - DIFF_BITS'(px);
        end
      end
      ST_SETM: begin
        base <= $signed({1'b0, vmin});
        d1   <= DIFF_BITS'(mp) - DIFF_BITS'(wmin);
        d2   <= $signed({1'b0, vmax}) - $signed({1'b0, vmin});
        den  <= DIFF_BITS'(wmax) - DIFF_BITS'(wmin);
      end
      ST_MUL: begin
        // start value when the divisor is zero
        res  <= base[COORD_BITS-1:0];
      end
      ST_DIV: begin
        if (div_done) res <= sum[COORD_BITS-1:0];
      end
      ST_UPD: begin
        if (mapping) begin
          case (map_idx)
            2'd0: out_item.out_start_x <= res;
            2'd1: out_item.out_start_y <= res;
            2'd2: out_item.out_end_x   <= res;
            default: out_item.out_end_y <= res;
          endcase
          map_idx <= map_idx + 1'b1;
        end else begin
          round <= round + 1'b1;
          if (move_a) begin
            ax <= nx;
            ay <= ny;
            ca <= region_code(nx, ny, cfg);
          end else begin
            bx <= nx;
            by <= ny;
            cb <= region_code(nx, ny, cfg);
          end
        end
      end
      default: ;
    endcase
  end

  // checks
  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV)
    else $error("divider running outside divide state");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_TEST |-> round <= ROUND_BITS'(ROUND_LIMIT))
    else $error("clip round count past limit");

  a_clip_loops_back: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && !mapping) |=> state == ST_TEST)
    else $error("clip update not followed by test");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.visible) |-> (out_item.out_start_x == '0 &&
      out_item.out_start_y == '0 && out_item.out_end_x == '0 &&
      out_item.out_end_y == '0))
    else $error("hidden segment with nonzero coordinates");

endmodule
